### design/fss_pkg.sv
// Shared types and constants for the fuzzy subsequence scorer.
package fss_pkg;

  localparam int CHAR_W      = 16;
  localparam int TERM_LEN_W  = 5;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int TERM_CHARS  = 16;
  localparam int CHARS_PER_W = 4;
  localparam int SCORE_W     = 9;
  localparam int RUN_W       = 8;
  localparam int KIND_W      = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_TERM_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_3   = 3'd4;

  localparam logic [KIND_W-1:0] KIND_TITLE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PLACE    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CATEGORY = 3'd2;
  localparam logic [KIND_W-1:0] KIND_HARNESS  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MACHINE  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SCREEN   = 3'd5;

  localparam logic [RUN_W-1:0]   PTS_LETTER   = 8'd1;
  localparam logic [RUN_W-1:0]   PTS_BOUNDARY = 8'd8;
  localparam logic [RUN_W-1:0]   PTS_CHAIN    = 8'd6;
  localparam logic [SCORE_W-1:0] PTS_PREFIX   = 9'd10;
  localparam logic [SCORE_W-1:0] PTS_SUBSTR   = 9'd6;
  localparam logic [SCORE_W-1:0] PTS_SCREEN   = 9'd4;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [KIND_W-1:0] field_kind;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic               matched;
    logic [SCORE_W-1:0] score;
  } out_item_t;

  function automatic logic [SCORE_W-1:0] field_bonus(input logic [KIND_W-1:0] kind);
    logic [SCORE_W-1:0] b;
    b = '0;
    unique case (kind)
      KIND_TITLE:    b = 9'd12;
      KIND_PLACE:    b = 9'd6;
      KIND_CATEGORY: b = 9'd6;
      KIND_HARNESS:  b = 9'd4;
      KIND_MACHINE:  b = 9'd6;
      default:       b = '0;
    endcase
    return b;
  endfunction

  function automatic logic is_separator(input logic [CHAR_W-1:0] c);
    return (c == 16'h002F) || (c == 16'h002D) || (c == 16'h005F) ||
           (c == 16'h002E) || (c == 16'h0020) || (c == 16'h003A) ||
           (c == 16'h007E);
  endfunction

endpackage

### design/fuzzy_subsequence_scorer.sv
// Fuzzy subsequence scorer: streams text characters against a configured term.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid/in_ready    in_data  (ch, field_kind, last)
//   out_     out  out_valid/out_ready  out_data (matched, score)
//   cfg_     in   cfg_we               cfg_idx, cfg_wdata
//
// One character per cycle while in_ready is high; the result of a text is shown
// in the cycle after its last character is taken, held in the output register.
// in_ready drops only while a result sits unread and out_ready is low.
// Substring and prefix hits come from a shift-and vector, one bit per term letter.
// Reset (synchronous) sets term_len to 1, clears the term and all text state.
module fuzzy_subsequence_scorer #(
  parameter int MAX_TERM = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  fss_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output fss_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [fss_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [fss_pkg::CFG_W-1:0]         cfg_wdata
);
  import fss_pkg::*;

  localparam int SEEN_W = $clog2(MAX_TERM + 1);

  // configuration
  logic [TERM_LEN_W-1:0] term_len_r;
  logic [CFG_W-1:0]      term_word_r [CHARS_PER_W];
  logic [CHAR_W-1:0]     term_chars  [TERM_CHARS];

  // per-text state
  logic [TERM_LEN_W-1:0] letters_r, letters_nxt;
  logic [RUN_W-1:0]      run_r, run_nxt;
  logic                  boost_r, boost_nxt;   // text start or after a separator
  logic                  chain_r, chain_nxt;   // previous character was a matched letter
  logic [MAX_TERM-1:0]   seq_r, seq_nxt;       // seq[j]: term[0..j] ends at this char
  logic [SEEN_W-1:0]     seen_r, seen_nxt;
  logic                  prefix_r, prefix_nxt;
  logic                  substr_r, substr_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                  in_accept;
  logic [TERM_LEN_W-1:0] eff_len;
  logic                  len_nz;
  logic [MAX_TERM-1:0]   eq;
  logic                  cur_eq;
  logic                  letter_hit;
  logic [RUN_W-1:0]      add;
  logic [TERM_LEN_W-1:0] upd_letters;
  logic [RUN_W-1:0]      upd_run;
  logic [MAX_TERM-1:0]   upd_seq;
  logic                  win_hit;
  logic                  upd_prefix;
  logic                  upd_substr;
  logic [SEEN_W-1:0]     upd_seen;
  logic [SCORE_W-1:0]    tail_bonus;
  out_item_t             result;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    for (int i = 0; i < TERM_CHARS; i++) begin
      term_chars[i] = term_word_r[i / CHARS_PER_W][(i % CHARS_PER_W) * CHAR_W +: CHAR_W];
    end
  end

  always_comb begin
    if (32'(term_len_r) > MAX_TERM) begin
      eff_len = TERM_LEN_W'(MAX_TERM);
    end else begin
      eff_len = term_len_r;
    end
    len_nz = (eff_len != '0);

    // letters past the configured words compare against code unit zero
    for (int j = 0; j < MAX_TERM; j++) begin
      if (j < TERM_CHARS) begin
        eq[j] = (in_data.ch == term_chars[j % TERM_CHARS]);
      end else begin
        eq[j] = (in_data.ch == '0);
      end
    end

    cur_eq = 1'b0;
    for (int j = 0; j < MAX_TERM; j++) begin
      if (32'(letters_r) == j) begin
        cur_eq = eq[j];
      end
    end
    letter_hit = len_nz && (letters_r < eff_len) && cur_eq;

    add = PTS_LETTER + (boost_r ? PTS_BOUNDARY : '0) + (chain_r ? PTS_CHAIN : '0);
    upd_run     = letter_hit ? run_r + add : run_r;
    upd_letters = letter_hit ? letters_r + 1'b1 : letters_r;

    upd_seq[0] = eq[0];
    for (int j = 1; j < MAX_TERM; j++) begin
      upd_seq[j] = seq_r[j-1] && eq[j];
    end

    win_hit = 1'b0;
    for (int j = 0; j < MAX_TERM; j++) begin
      if (32'(eff_len) == j + 1) begin
        win_hit = upd_seq[j];
      end
    end

    upd_seen   = (32'(seen_r) < MAX_TERM) ? seen_r + 1'b1 : seen_r;
    upd_substr = substr_r || win_hit;
    upd_prefix = prefix_r || (win_hit && (32'(seen_r) + 1 == 32'(eff_len)));

    if (upd_prefix) begin
      tail_bonus = PTS_PREFIX;
    end else if (upd_substr) begin
      tail_bonus = PTS_SUBSTR;
    end else begin
      tail_bonus = '0;
    end

    result = '0;
    if (len_nz) begin
      if (in_data.field_kind == KIND_SCREEN) begin
        if (upd_substr) begin
          result.matched = 1'b1;
          result.score   = PTS_SCREEN + SCORE_W'(eff_len);
        end
      end else if ((in_data.field_kind < KIND_SCREEN) && (upd_letters == eff_len)) begin
        result.matched = 1'b1;
        result.score   = SCORE_W'(upd_run) + tail_bonus + field_bonus(in_data.field_kind);
      end
    end

    // the last character of a text returns all text state to its start values
    if (in_data.last) begin
      letters_nxt = '0;
      run_nxt     = '0;
      boost_nxt   = 1'b1;
      chain_nxt   = 1'b0;
      seq_nxt     = '0;
      seen_nxt    = '0;
      prefix_nxt  = 1'b0;
      substr_nxt  = 1'b0;
    end else begin
      letters_nxt = upd_letters;
      run_nxt     = upd_run;
      boost_nxt   = is_separator(in_data.ch);
      chain_nxt   = letter_hit;
      seq_nxt     = upd_seq;
      seen_nxt    = upd_seen;
      prefix_nxt  = upd_prefix;
      substr_nxt  = upd_substr;
    end

    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (in_accept && in_data.last) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_len_r <= TERM_LEN_W'(1);
      for (int i = 0; i < CHARS_PER_W; i++) begin
        term_word_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_TERM_LEN: term_len_r     <= cfg_wdata[TERM_LEN_W-1:0];
        CFG_WORD_0:   term_word_r[0] <= cfg_wdata;
        CFG_WORD_1:   term_word_r[1] <= cfg_wdata;
        CFG_WORD_2:   term_word_r[2] <= cfg_wdata;
        CFG_WORD_3:   term_word_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      letters_r   <= '0;
      run_r       <= '0;
      boost_r     <= 1'b1;
      chain_r     <= 1'b0;
      seq_r       <= '0;
      seen_r      <= '0;
      prefix_r    <= 1'b0;
      substr_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        letters_r <= letters_nxt;
        run_r     <= run_nxt;
        boost_r   <= boost_nxt;
        chain_r   <= chain_nxt;
        seq_r     <= seq_nxt;
        seen_r    <= seen_nxt;
        prefix_r  <= prefix_nxt;
        substr_r  <= substr_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
